// ===== rtl/xsr512_pkg.sv =====
`timescale 1ns / 1ps

package xsr512_pkg;

   localparam int WORD_W  = 64;
   localparam int HALF_W  = 32;
   localparam int SEED_W  = 32;
   localparam int KIND_W  = 2;
   localparam int INDEX_W = 3;
   localparam int NUM_WORDS = 8;

   // Transaction kinds on the request channel.
   localparam logic [KIND_W-1:0] KIND_GEN   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SEED  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd3;

   // Splitmix64 constants.
   localparam logic [WORD_W-1:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [WORD_W-1:0] MIX_MUL_A   = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [WORD_W-1:0] MIX_MUL_B   = 64'h94D0_49BB_1331_11EB;

   // Datapath operations issued by the controller.
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NONE  = 4'd0;
   localparam logic [OP_W-1:0] OP_GEN   = 4'd1;
   localparam logic [OP_W-1:0] OP_WRITE = 4'd2;
   localparam logic [OP_W-1:0] OP_READ  = 4'd3;
   localparam logic [OP_W-1:0] OP_SEED  = 4'd4;
   localparam logic [OP_W-1:0] OP_CLEAR = 4'd5;
   localparam logic [OP_W-1:0] OP_MIX   = 4'd6;
   localparam logic [OP_W-1:0] OP_MUL   = 4'd7;
   localparam logic [OP_W-1:0] OP_FOLD  = 4'd8;
   localparam logic [OP_W-1:0] OP_STORE = 4'd9;

   // Partial product steps of the 64 by 64 multiply (low half of the result).
   localparam logic [1:0] MUL_LO_LO = 2'd0;
   localparam logic [1:0] MUL_HI_LO = 2'd1;
   localparam logic [1:0] MUL_LO_HI = 2'd2;

   localparam logic MUL_CONST_A = 1'b0;
   localparam logic MUL_CONST_B = 1'b1;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [1:0]         mul_step;
      logic               mul_const;
      logic [INDEX_W-1:0] word_sel;
   } cmd_type;

endpackage

// ===== rtl/xsr512_if.sv =====
`timescale 1ns / 1ps

interface xsr512_req_if;
   import xsr512_pkg::*;
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [SEED_W-1:0]   seed_in;
   logic [INDEX_W-1:0]  word_index;
   logic [WORD_W-1:0]   word_value;

   modport source (output valid, kind, seed_in, word_index, word_value, input ready);
   modport sink   (input valid, kind, seed_in, word_index, word_value, output ready);
endinterface

interface xsr512_rsp_if;
   import xsr512_pkg::*;
   logic                valid;
   logic                ready;
   logic [WORD_W-1:0]   value_out;

   modport source (output valid, value_out, input ready);
   modport sink   (input valid, value_out, output ready);
endinterface

// ===== rtl/xsr512_datapath.sv =====
`timescale 1ns / 1ps

module xsr512_datapath (
   input  logic                         clock,
   input  xsr512_pkg::cmd_type          cmd,
   input  logic [xsr512_pkg::SEED_W-1:0]  seed_in,
   input  logic [xsr512_pkg::INDEX_W-1:0] word_index,
   input  logic [xsr512_pkg::WORD_W-1:0]  word_value,
   output logic [xsr512_pkg::WORD_W-1:0]  value_out
);
   import xsr512_pkg::*;

   function automatic logic [WORD_W-1:0] rot_left(input logic [WORD_W-1:0] v,
                                                   input int amount);
      rot_left = (v << amount) | (v >> (WORD_W - amount));
   endfunction

   logic [WORD_W-1:0] words_ff [NUM_WORDS];
   logic [WORD_W-1:0] words_in [NUM_WORDS];
   logic [WORD_W-1:0] counter_ff, counter_in;
   logic [WORD_W-1:0] z_ff, z_in;
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [WORD_W-1:0] out_ff, out_in;

   logic [WORD_W-1:0] gen_result;
   logic [WORD_W-1:0] gen_words [NUM_WORDS];
   logic [WORD_W-1:0] shifted;
   logic [WORD_W-1:0] mix_count;
   logic [WORD_W-1:0] mul_const;
   logic [HALF_W-1:0] mul_a, mul_b;
   logic [WORD_W-1:0] product;

   // xoshiro512 state update and output function.
   always_comb begin
      shifted      = words_ff[1] << 11;
      gen_result   = rot_left(words_ff[0] + words_ff[2], 17) + words_ff[2];
      gen_words[2] = words_ff[2] ^ words_ff[0];
      gen_words[5] = words_ff[5] ^ words_ff[1];
      gen_words[1] = words_ff[1] ^ gen_words[2];
      gen_words[3] = words_ff[3] ^ words_ff[4];
      gen_words[4] = words_ff[4] ^ gen_words[5];
      gen_words[0] = words_ff[0] ^ words_ff[6];
      gen_words[6] = words_ff[6] ^ words_ff[7] ^ words_ff[3] ^ shifted;
      gen_words[7] = rot_left(words_ff[7] ^ words_ff[3], 21);
   end

   // One shared 32 by 32 multiplier builds the low 64 bits of z times a constant
   // over three steps.
   always_comb begin
      mul_const = (cmd.mul_const == MUL_CONST_B) ? MIX_MUL_B : MIX_MUL_A;
      case (cmd.mul_step)
         MUL_LO_LO: begin
            mul_a = z_ff[HALF_W-1:0];
            mul_b = mul_const[HALF_W-1:0];
         end
         MUL_HI_LO: begin
            mul_a = z_ff[WORD_W-1:HALF_W];
            mul_b = mul_const[HALF_W-1:0];
         end
         default: begin
            mul_a = z_ff[HALF_W-1:0];
            mul_b = mul_const[WORD_W-1:HALF_W];
         end
      endcase
      product = mul_a * mul_b;
   end

   always_comb begin
      words_in   = words_ff;
      counter_in = counter_ff;
      z_in       = z_ff;
      acc_in     = acc_ff;
      out_in     = out_ff;
      mix_count  = counter_ff + GOLDEN_STEP;
      case (cmd.op)
         OP_GEN: begin
            words_in = gen_words;
            out_in   = gen_result;
         end
         OP_WRITE: words_in[word_index] = word_value;
         OP_READ:  out_in = words_ff[word_index];
         OP_SEED:  counter_in = {{(WORD_W-SEED_W){1'b0}}, seed_in};
         OP_CLEAR: counter_in = '0;
         OP_MIX: begin
            counter_in = mix_count;
            z_in       = mix_count ^ (mix_count >> 30);
         end
         OP_MUL: begin
            if (cmd.mul_step == MUL_LO_LO) begin
               acc_in = product;
            end else begin
               acc_in = acc_ff + {product[HALF_W-1:0], {HALF_W{1'b0}}};
            end
         end
         OP_FOLD:  z_in = acc_ff ^ (acc_ff >> 27);
         OP_STORE: words_in[cmd.word_sel] = acc_ff ^ (acc_ff >> 31);
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      words_ff   <= words_in;
      counter_ff <= counter_in;
      z_ff       <= z_in;
      acc_ff     <= acc_in;
      out_ff     <= out_in;
   end

   assign value_out = out_ff;

endmodule

// ===== rtl/xsr512_ctrl.sv =====
`timescale 1ns / 1ps

module xsr512_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [xsr512_pkg::KIND_W-1:0] req_kind,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output xsr512_pkg::cmd_type           cmd
);
   import xsr512_pkg::*;

   localparam logic [3:0] ST_INIT  = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_MIX   = 4'd2;
   localparam logic [3:0] ST_MA0   = 4'd3;
   localparam logic [3:0] ST_MA1   = 4'd4;
   localparam logic [3:0] ST_MA2   = 4'd5;
   localparam logic [3:0] ST_FOLD  = 4'd6;
   localparam logic [3:0] ST_MB0   = 4'd7;
   localparam logic [3:0] ST_MB1   = 4'd8;
   localparam logic [3:0] ST_MB2   = 4'd9;
   localparam logic [3:0] ST_STORE = 4'd10;

   logic [3:0]         state_ff, state_in;
   logic [INDEX_W-1:0] word_ff, word_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               req_accept;

   // The result register may be refilled in the cycle its value is taken.
   assign req_ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      word_in       = word_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      cmd.op        = OP_NONE;
      cmd.mul_step  = MUL_LO_LO;
      cmd.mul_const = MUL_CONST_A;
      cmd.word_sel  = word_ff;
      case (state_ff)
         ST_INIT: begin
            cmd.op   = OP_CLEAR;
            word_in  = '0;
            state_in = ST_MIX;
         end
         ST_IDLE: begin
            if (req_accept) begin
               case (req_kind)
                  KIND_GEN: begin
                     cmd.op       = OP_GEN;
                     rsp_valid_in = 1'b1;
                  end
                  KIND_SEED: begin
                     cmd.op   = OP_SEED;
                     word_in  = '0;
                     state_in = ST_MIX;
                  end
                  KIND_WRITE: cmd.op = OP_WRITE;
                  default: begin
                     cmd.op       = OP_READ;
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_MIX: begin
            cmd.op   = OP_MIX;
            state_in = ST_MA0;
         end
         ST_MA0: begin
            cmd.op   = OP_MUL;
            state_in = ST_MA1;
         end
         ST_MA1: begin
            cmd.op       = OP_MUL;
            cmd.mul_step = MUL_HI_LO;
            state_in     = ST_MA2;
         end
         ST_MA2: begin
            cmd.op       = OP_MUL;
            cmd.mul_step = MUL_LO_HI;
            state_in     = ST_FOLD;
         end
         ST_FOLD: begin
            cmd.op   = OP_FOLD;
            state_in = ST_MB0;
         end
         ST_MB0: begin
            cmd.op        = OP_MUL;
            cmd.mul_const = MUL_CONST_B;
            state_in      = ST_MB1;
         end
         ST_MB1: begin
            cmd.op        = OP_MUL;
            cmd.mul_step  = MUL_HI_LO;
            cmd.mul_const = MUL_CONST_B;
            state_in      = ST_MB2;
         end
         ST_MB2: begin
            cmd.op        = OP_MUL;
            cmd.mul_step  = MUL_LO_HI;
            cmd.mul_const = MUL_CONST_B;
            state_in      = ST_STORE;
         end
         ST_STORE: begin
            cmd.op  = OP_STORE;
            word_in = word_ff + 1'b1;
            if (word_ff == INDEX_W'(NUM_WORDS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_MIX;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         word_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/xoshiro512pp_generator_top.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Contents
// req_if    in         kind, seed_in, word_index, word_value
// rsp_if    out        value_out (generated number or state word read back)
//
// Generate, write and read transactions can follow back to back while each
// result is taken; the result sits in an output register, so a new request is
// taken in the same cycle the previous result leaves. A reseed loads the seed,
// then per state word a mix, three multiply steps, a fold, three more multiply
// steps and a store; the shared 32x32 multiplier forms each 64-bit splitmix64
// product in three steps. After reset the same expansion runs for seed zero,
// with req_if.ready low. A stalled result holds its value until rsp_if.ready.

module xoshiro512pp_generator_top (
   input  logic         clock,
   input  logic         reset,
   xsr512_req_if.sink   req_if,
   xsr512_rsp_if.source rsp_if
);
   import xsr512_pkg::*;

   cmd_type cmd;
   logic    req_ready;
   logic    rsp_valid;

   // The controller sequences seeding and owns the handshake; the datapath
   // holds the eight state words, the splitmix64 registers and the result.
   xsr512_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_kind  (req_if.kind),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd)
   );

   xsr512_datapath u_datapath (
      .clock      (clock),
      .cmd        (cmd),
      .seed_in    (req_if.seed_in),
      .word_index (req_if.word_index),
      .word_value (req_if.word_value),
      .value_out  (rsp_if.value_out)
   );

   assign req_if.ready = req_ready;
   assign rsp_if.valid = rsp_valid;

endmodule

// ===== rtl/xsr512_checker.sv =====
`timescale 1ns / 1ps

module xsr512_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [xsr512_pkg::KIND_W-1:0] req_kind,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [xsr512_pkg::WORD_W-1:0] rsp_value
);
   import xsr512_pkg::*;

   // A result that is not taken stays offered with the same value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
      else $error("result dropped or changed while stalled");

   // Generate and read transactions produce a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind == KIND_GEN || req_kind == KIND_READ)
      |=> rsp_valid)
      else $error("missing result after generate or read");

   // A reseed occupies the block, so no request is taken right after it.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == KIND_SEED |=> !req_ready)
      else $error("request taken during reseed");

   // Write transactions produce no result.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == KIND_WRITE && (!rsp_valid || rsp_ready)
      |=> !rsp_valid)
      else $error("unexpected result after write");

endmodule

bind xoshiro512pp_generator_top xsr512_checker u_xsr512_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .req_kind  (req_if.kind),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_value (rsp_if.value_out)
);
